// File: hdl/lprv_pkg.sv
package lprv_pkg;

  // parse phases, one per field of the record layout
  typedef enum logic [4:0] {
    PH_MAGIC     = 5'd0,
    PH_VERSION   = 5'd1,
    PH_RUN0_CNT  = 5'd2,
    PH_RUN0_ELEM = 5'd3,
    PH_RUN1_CNT  = 5'd4,
    PH_RUN1_ELEM = 5'd5,
    PH_RUN2_CNT  = 5'd6,
    PH_RUN2_ELEM = 5'd7,
    PH_RUN3_CNT  = 5'd8,
    PH_RUN3_ELEM = 5'd9,
    PH_DIG0      = 5'd10,
    PH_DIG1      = 5'd11,
    PH_EXTCOUNT  = 5'd12,
    PH_TAGLEN    = 5'd13,
    PH_TAGBYTE   = 5'd14,
    PH_PAYLEN    = 5'd15,
    PH_PAYBYTE   = 5'd16,
    PH_DISCARD   = 5'd17
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_MAGIC    = 3'd1,
    ERR_VERSION  = 3'd2,
    ERR_TRUNC    = 3'd3,
    ERR_LENGTH   = 3'd4,
    ERR_TRAILING = 3'd5
  } err_t;

  // result kinds that do not follow from the phase
  localparam logic [4:0] KIND_DONE  = 5'd15;
  localparam logic [4:0] KIND_ERROR = 5'd16;

  // offset between a field phase and its result kind
  localparam logic [4:0] KIND_OFFSET = 5'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_VERSION = 2'd1;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [4:0]  kind;
    logic [63:0] value;
    err_t        error_code;
    logic        last_result;
  } res_t;

  // up to two results produced by one byte
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h48;
      3'd1: b = 8'h56;
      3'd2: b = 8'h45;
      3'd3: b = 8'h4E;
      3'd4: b = 8'h57;
      3'd5: b = 8'h53;
      3'd6: b = 8'h44;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // append a result to a push group
  function automatic push_t add_res(input push_t p, input logic [4:0] k,
                                    input logic [63:0] v, input err_t e);
    push_t q;
    q = p;
    if (p.count == 2'd0) begin
      q.r0 = '{kind: k, value: v, error_code: e, last_result: 1'b0};
      q.count = 2'd1;
    end else begin
      q.r1 = '{kind: k, value: v, error_code: e, last_result: 1'b0};
      q.count = 2'd2;
    end
    return q;
  endfunction

endpackage

// File: hdl/lprv_parse.sv
module lprv_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           data_byte,
  input  logic [31:0]          payload_length,
  input  logic [31:0]          expected_version,
  output lprv_pkg::push_t      push
);
  import lprv_pkg::*;

  // parse state
  phase_t      phase;
  logic [2:0]  field_byte_index;
  logic [63:0] assembly_register;
  logic [31:0] byte_offset;
  logic [31:0] run_elements_left;
  logic [31:0] extensions_left;
  logic        magic_mismatch;

  phase_t      phase_next;
  logic [2:0]  field_byte_index_next;
  logic [63:0] assembly_register_next;
  logic [31:0] byte_offset_next;
  logic [31:0] run_elements_left_next;
  logic [31:0] extensions_left_next;
  logic        magic_mismatch_next;

  logic [31:0] eff;
  logic [31:0] oa;
  logic        pend;
  logic [31:0] rem;
  logic [63:0] v;
  logic        field_last;
  logic        ended;
  logic        do_ext_next;
  logic        do_finish;
  err_t        fail_code;
  logic [4:0]  kind_ph;
  logic        over8;
  logic        over16;
  logic        over1;
  push_t       p;

  // offset, effective length and bytes remaining after this byte
  always_comb begin
    eff  = (payload_length == 32'd0) ? 32'd1 : payload_length;
    oa   = (byte_offset != '1) ? byte_offset + 32'd1 : byte_offset;
    pend = (oa >= eff);
    rem  = pend ? 32'd0 : eff - oa;
  end

  // assembled field value including this byte
  always_comb begin
    v = assembly_register | (64'(data_byte) << {field_byte_index, 3'b000});
    field_last = (phase == PH_VERSION) ? (field_byte_index == 3'd3)
                                       : (field_byte_index == 3'd7);
    kind_ph = 5'(phase) - KIND_OFFSET;
    over8  = (v[63:32] != 32'd0) || (v[31:0] > {3'b000, rem[31:3]});
    over16 = (v[63:32] != 32'd0) || (v[31:0] > {4'b0000, rem[31:4]});
    over1  = (v[63:32] != 32'd0) || (v[31:0] > rem);
  end

  // per-byte step
  always_comb begin
    phase_next             = phase;
    field_byte_index_next  = field_byte_index;
    assembly_register_next = assembly_register;
    byte_offset_next       = oa;
    run_elements_left_next = run_elements_left;
    extensions_left_next   = extensions_left;
    magic_mismatch_next    = magic_mismatch;
    do_ext_next            = 1'b0;
    do_finish              = 1'b0;
    fail_code              = ERR_NONE;
    ended                  = 1'b0;
    p                      = '0;

    case (phase)
      // raw bytes of a tag or payload
      PH_TAGBYTE, PH_PAYBYTE: begin
        p = add_res(p, kind_ph, 64'(data_byte), ERR_NONE);
        if (run_elements_left != 32'd0)
          run_elements_left_next = run_elements_left - 32'd1;
        if (run_elements_left <= 32'd1) begin
          if (phase == PH_TAGBYTE) phase_next = PH_PAYLEN;
          else do_ext_next = 1'b1;
        end
      end
      PH_DISCARD: begin
        phase_next = PH_DISCARD;
      end
      // little-endian fixed-size fields
      default: begin
        if (phase == PH_MAGIC && data_byte != magic_byte(field_byte_index))
          magic_mismatch_next = 1'b1;
        if (!field_last) begin
          field_byte_index_next  = field_byte_index + 3'd1;
          assembly_register_next = v;
        end else begin
          field_byte_index_next  = 3'd0;
          assembly_register_next = '0;
          case (phase)
            PH_MAGIC: begin
              if (magic_mismatch_next) fail_code = ERR_MAGIC;
              else phase_next = PH_VERSION;
            end
            PH_VERSION: begin
              if (v[31:0] != expected_version) fail_code = ERR_VERSION;
              else phase_next = PH_RUN0_CNT;
            end
            PH_RUN0_CNT, PH_RUN1_CNT, PH_RUN2_CNT, PH_RUN3_CNT: begin
              if (over8) begin
                fail_code = ERR_LENGTH;
              end else begin
                p = add_res(p, kind_ph, v, ERR_NONE);
                run_elements_left_next = v[31:0];
                // empty run skips its element phase
                phase_next = (v == 64'd0) ? phase_t'(phase + 5'd2)
                                          : phase_t'(phase + 5'd1);
              end
            end
            PH_RUN0_ELEM, PH_RUN1_ELEM, PH_RUN2_ELEM, PH_RUN3_ELEM: begin
              p = add_res(p, kind_ph, v, ERR_NONE);
              if (run_elements_left != 32'd0)
                run_elements_left_next = run_elements_left - 32'd1;
              if (run_elements_left <= 32'd1)
                phase_next = phase_t'(phase + 5'd1);
            end
            PH_DIG0, PH_DIG1: begin
              p = add_res(p, kind_ph, v, ERR_NONE);
              phase_next = phase_t'(phase + 5'd1);
            end
            PH_EXTCOUNT: begin
              if (over16) begin
                fail_code = ERR_LENGTH;
              end else begin
                p = add_res(p, kind_ph, v, ERR_NONE);
                extensions_left_next = v[31:0];
                if (v == 64'd0) do_finish = 1'b1;
                else phase_next = PH_TAGLEN;
              end
            end
            PH_TAGLEN, PH_PAYLEN: begin
              if (over1) begin
                fail_code = ERR_LENGTH;
              end else begin
                p = add_res(p, kind_ph, v, ERR_NONE);
                run_elements_left_next = v[31:0];
                if (v != 64'd0) phase_next = phase_t'(phase + 5'd1);
                else if (phase == PH_TAGLEN) phase_next = PH_PAYLEN;
                else do_ext_next = 1'b1;
              end
            end
            default: phase_next = PH_DISCARD;
          endcase
        end
      end
    endcase

    // move to the next extension or close the record
    if (do_ext_next) begin
      if (extensions_left <= 32'd1) begin
        extensions_left_next = 32'd0;
        do_finish = 1'b1;
      end else begin
        extensions_left_next = extensions_left - 32'd1;
        phase_next = PH_TAGLEN;
      end
    end
    if (do_finish) begin
      if (rem == 32'd0) begin
        p = add_res(p, KIND_DONE, 64'd0, ERR_NONE);
        ended = 1'b1;
        phase_next = PH_DISCARD;
      end else begin
        fail_code = ERR_TRAILING;
      end
    end
    if (fail_code != ERR_NONE) begin
      p = add_res(p, KIND_ERROR, 64'd0, fail_code);
      ended = 1'b1;
      phase_next = PH_DISCARD;
    end

    // payload ended inside an open record
    if (pend && !ended && phase_next != PH_DISCARD)
      p = add_res(p, KIND_ERROR, 64'd0, ERR_TRUNC);

    if (p.count == 2'd1) p.r0.last_result = 1'b1;
    else if (p.count == 2'd2) p.r1.last_result = 1'b1;

    // payload end restarts the parse
    if (pend) begin
      phase_next             = PH_MAGIC;
      field_byte_index_next  = 3'd0;
      assembly_register_next = '0;
      byte_offset_next       = 32'd0;
      run_elements_left_next = 32'd0;
      extensions_left_next   = 32'd0;
      magic_mismatch_next    = 1'b0;
    end
  end

  // result group handed to the queue
  always_comb begin
    push = p;
    if (!fire) push.count = 2'd0;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_MAGIC;
      field_byte_index  <= 3'd0;
      assembly_register <= '0;
      byte_offset       <= 32'd0;
      run_elements_left <= 32'd0;
      extensions_left   <= 32'd0;
      magic_mismatch    <= 1'b0;
    end else if (fire) begin
      phase             <= phase_next;
      field_byte_index  <= field_byte_index_next;
      assembly_register <= assembly_register_next;
      byte_offset       <= byte_offset_next;
      run_elements_left <= run_elements_left_next;
      extensions_left   <= extensions_left_next;
      magic_mismatch    <= magic_mismatch_next;
    end
  end

endmodule

// File: hdl/lprv_result_fifo.sv
module lprv_result_fifo (
  input  logic             clk,
  input  logic             rst,
  input  lprv_pkg::push_t  push,
  output logic             room2,
  input  logic             pop,
  output logic             out_valid,
  output lprv_pkg::res_t   out_res
);
  import lprv_pkg::*;

  res_t                 mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_AW:0]     count;
  logic                 pop_ok;

  // status
  always_comb begin
    room2     = (count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    out_valid = (count != '0);
    out_res   = mem[rd_ptr];
    pop_ok    = pop && out_valid;
  end

  // storage, up to two writes per cycle
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.r0;
    if (push.count == 2'd2) mem[wr_ptr + FIFO_AW'(1)] <= push.r1;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.count);
      if (pop_ok) rd_ptr <= rd_ptr + FIFO_AW'(1);
      count <= count + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop_ok);
    end
  end

endmodule

// File: hdl/length_prefixed_record_validator.sv
// a byte's results pass through the input register and the result queue before m_tvalid offers them,
// and a queue without two free entries holds the byte in the input register
// throughput: one byte per cycle while the result queue keeps two free entries
// a byte gives up to two results; the four-entry result queue absorbs the burst
// reset: synchronous active-high rst clears the parse, queue and input register,
// and sets payload_length to 1 and expected_version to 2
module length_prefixed_record_validator (
  input  logic                              clk,
  input  logic                              rst,
  // input bytes
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,    // [7:0] data_byte
  // results
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [71:0]                       m_tdata,    // [63:0] value, [66:64] error_code
  output logic [4:0]                        m_tuser,    // [4:0] kind
  output logic                              m_tlast,    // last_result
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lprv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data
);
  import lprv_pkg::*;

  logic [31:0] payload_length;
  logic [31:0] expected_version;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        room2;
  logic        fire;
  push_t       push;
  res_t        out_res;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_length   <= 32'd1;
      expected_version <= 32'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PAYLOAD_LENGTH:   payload_length   <= cfg_data;
        REG_EXPECTED_VERSION: expected_version <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  assign fire     = in_valid && room2;
  assign s_tready = !in_valid || fire;
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_byte <= s_tdata;
  end

  lprv_parse u_parse (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .data_byte        (in_byte),
    .payload_length   (payload_length),
    .expected_version (expected_version),
    .push             (push)
  );

  lprv_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room2     (room2),
    .pop       (m_tready),
    .out_valid (m_tvalid),
    .out_res   (out_res)
  );

  // result packing
  assign m_tdata = {5'd0, out_res.error_code, out_res.value};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last_result;

endmodule

// File: verif/testbench.sv
module testbench;
  import lprv_pkg::*;

  localparam logic [31:0] OFFSET_MAX   = 32'hFFFF_FFFF;
  // the eight signature bytes, first byte in the lowest bits
  localparam logic [63:0] SIGNATURE    = 64'h0044_5357_4E45_5648;
  // input bytes for the whole run, directed tests included
  localparam int          ITEM_TARGET  = 600;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          REPORT_LIMIT = 20;
  // register indexes past the end of the map
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = 8'h00;
  logic                 m_tvalid;
  logic                 m_tready = 1'b1;
  logic [71:0]          m_tdata;
  logic [4:0]           m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = 32'd0;

  length_prefixed_record_validator DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // parser copy: configuration
  logic [31:0] mdl_payload_len;
  logic [31:0] mdl_version;
  // parser copy: state
  phase_t      mdl_phase;
  logic [2:0]  mdl_index;
  logic [63:0] mdl_acc;
  logic [31:0] mdl_offset;
  logic [63:0] mdl_left;
  logic [63:0] mdl_exts;
  logic        mdl_mismatch;
  // results caused by the byte being parsed
  res_t        step_res [2];
  int          step_count;
  logic        step_ended;

  res_t        pending_results [$];

  int errors = 0;
  int bytes_sent = 0;
  int payloads_sent = 0;
  int results_seen = 0;
  int burst_left = 0;

  // record image being sent, and its shape
  logic [7:0]  rec [$];
  int          run_len [4];
  int          ext_n;
  int          tag_len [3];
  int          pay_len [3];
  int          ext_pos;

  // ---------------------------------------------------------------- parser copy

  task automatic restart_parse();
    mdl_phase    = PH_MAGIC;
    mdl_index    = 3'd0;
    mdl_acc      = 64'd0;
    mdl_offset   = 32'd0;
    mdl_left     = 64'd0;
    mdl_exts     = 64'd0;
    mdl_mismatch = 1'b0;
  endtask

  task automatic add_result(input logic [4:0] k, input logic [63:0] v, input err_t e);
    if (step_count < 2) begin
      step_res[step_count] = '{kind: k, value: v, error_code: e, last_result: 1'b0};
      step_count++;
    end
  endtask

  task automatic fail_record(input err_t e);
    add_result(KIND_ERROR, 64'd0, e);
    step_ended = 1'b1;
    mdl_phase  = PH_DISCARD;
  endtask

  task automatic finish_record(input logic [31:0] rem);
    if (rem == 32'd0) begin
      add_result(KIND_DONE, 64'd0, ERR_NONE);
      step_ended = 1'b1;
      mdl_phase  = PH_DISCARD;
    end else begin
      fail_record(ERR_TRAILING);
    end
  endtask

  task automatic next_extension(input logic [31:0] rem);
    if (mdl_exts <= 64'd1) begin
      mdl_exts = 64'd0;
      finish_record(rem);
    end else begin
      mdl_exts--;
      mdl_phase = PH_TAGLEN;
    end
  endtask

  // works out the results of one accepted byte and queues them
  task automatic validate_byte(input logic [7:0] b);
    logic [31:0] eff;
    logic [31:0] oa;
    logic [31:0] rem;
    logic        at_end;
    int          idx;
    int          size;
    int          i;
    logic [63:0] v;
    eff    = (mdl_payload_len == 32'd0) ? 32'd1 : mdl_payload_len;
    oa     = (mdl_offset < OFFSET_MAX) ? mdl_offset + 32'd1 : OFFSET_MAX;
    at_end = (oa >= eff);
    rem    = at_end ? 32'd0 : eff - oa;
    step_count = 0;
    step_ended = 1'b0;

    if (mdl_phase == PH_TAGBYTE || mdl_phase == PH_PAYBYTE) begin
      // raw tag or payload byte
      add_result(mdl_phase - KIND_OFFSET, {56'd0, b}, ERR_NONE);
      if (mdl_left != 64'd0) mdl_left--;
      if (mdl_left == 64'd0) begin
        if (mdl_phase == PH_TAGBYTE) mdl_phase = PH_PAYLEN;
        else next_extension(rem);
      end
    end else if (mdl_phase != PH_DISCARD) begin
      // little-endian field assembly
      size = (mdl_phase == PH_VERSION) ? 4 : 8;
      idx  = mdl_index;
      if (mdl_phase == PH_MAGIC && b != SIGNATURE[8*idx +: 8]) mdl_mismatch = 1'b1;
      mdl_acc = mdl_acc | (64'(b) << (8 * idx));
      if (idx + 1 < size) begin
        mdl_index = 3'(idx + 1);
      end else begin
        v         = mdl_acc;
        mdl_index = 3'd0;
        mdl_acc   = 64'd0;
        case (mdl_phase)
          PH_MAGIC: begin
            if (mdl_mismatch) fail_record(ERR_MAGIC);
            else mdl_phase = PH_VERSION;
          end
          PH_VERSION: begin
            if (v[31:0] != mdl_version) fail_record(ERR_VERSION);
            else mdl_phase = PH_RUN0_CNT;
          end
          PH_RUN0_CNT, PH_RUN1_CNT, PH_RUN2_CNT, PH_RUN3_CNT: begin
            if (v > {32'd0, rem >> 3}) begin
              fail_record(ERR_LENGTH);
            end else begin
              add_result(mdl_phase - KIND_OFFSET, v, ERR_NONE);
              mdl_left = v;
              if (v == 64'd0) mdl_phase = phase_t'((mdl_phase | 5'd1) + 5'd1);
              else mdl_phase = phase_t'(mdl_phase + 5'd1);
            end
          end
          PH_RUN0_ELEM, PH_RUN1_ELEM, PH_RUN2_ELEM, PH_RUN3_ELEM: begin
            add_result(mdl_phase - KIND_OFFSET, v, ERR_NONE);
            if (mdl_left != 64'd0) mdl_left--;
            if (mdl_left == 64'd0) mdl_phase = phase_t'((mdl_phase | 5'd1) + 5'd1);
          end
          PH_DIG0, PH_DIG1: begin
            add_result(mdl_phase - KIND_OFFSET, v, ERR_NONE);
            mdl_phase = phase_t'(mdl_phase + 5'd1);
          end
          PH_EXTCOUNT: begin
            if (v > {32'd0, rem >> 4}) begin
              fail_record(ERR_LENGTH);
            end else begin
              add_result(mdl_phase - KIND_OFFSET, v, ERR_NONE);
              mdl_exts = v;
              if (v == 64'd0) finish_record(rem);
              else mdl_phase = PH_TAGLEN;
            end
          end
          PH_TAGLEN, PH_PAYLEN: begin
            if (v > {32'd0, rem}) begin
              fail_record(ERR_LENGTH);
            end else begin
              add_result(mdl_phase - KIND_OFFSET, v, ERR_NONE);
              mdl_left = v;
              if (v != 64'd0) mdl_phase = phase_t'(mdl_phase + 5'd1);
              else if (mdl_phase == PH_TAGLEN) mdl_phase = PH_PAYLEN;
              else next_extension(rem);
            end
          end
          default: ;
        endcase
      end
    end

    // payload ran out before the record finished
    if (at_end && !step_ended && mdl_phase != PH_DISCARD) fail_record(ERR_TRUNC);
    if (step_count > 0) step_res[step_count-1].last_result = 1'b1;
    for (i = 0; i < step_count; i++)
      pending_results.insert(pending_results.size(), step_res[i]);
    if (at_end) restart_parse();
    else mdl_offset = oa;
  endtask

  // ---------------------------------------------------------------- drivers

  // one input transaction, with bursts and gaps
  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    bytes_sent++;
    validate_byte(b);
  endtask

  // stop sending and wait for every queued result
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PAYLOAD_LENGTH:   mdl_payload_len = val;
      REG_EXPECTED_VERSION: mdl_version     = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver stall pattern, chosen by the upper bits of a free-running counter
  logic [8:0] rx_cycle = 9'd0;
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 9'd1;
    case (rx_cycle[8:7])
      2'd0:    m_tready <= 1'b1;
      2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    m_tready <= (rx_cycle[2:0] < 3'd3);
      default: m_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t unexpected result: expected none, got kind %0d value %h err %0d last %0b",
                   $time, m_tuser, m_tdata[63:0], m_tdata[66:64], m_tlast);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.kind || m_tdata[63:0] !== want.value ||
            m_tdata[66:64] !== want.error_code || m_tlast !== want.last_result) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $write("%0t mismatch: expected kind %0d value %h err %0d last %0b,",
                   $time, want.kind, want.value, want.error_code, want.last_result);
            $display(" got kind %0d value %h err %0d last %0b",
                     m_tuser, m_tdata[63:0], m_tdata[66:64], m_tlast);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("[length_prefixed_record_validator] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- record builder

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 64'd0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic put_le(input logic [63:0] v, input int n);
    int i;
    for (i = 0; i < n; i++) rec.insert(rec.size(), v[8*i +: 8]);
  endtask

  task automatic poke_le(input int pos, input logic [63:0] v);
    int i;
    for (i = 0; i < 8; i++) rec[pos+i] = v[8*i +: 8];
  endtask

  task automatic pick_shape(input int max_run, input int max_ext);
    int i;
    for (i = 0; i < 4; i++) run_len[i] = $urandom_range(0, max_run);
    ext_n = $urandom_range(0, max_ext);
    for (i = 0; i < 3; i++) begin
      tag_len[i] = $urandom_range(0, 4);
      pay_len[i] = $urandom_range(0, 6);
    end
  endtask

  // well-formed record of the current shape with random content
  task automatic build_record(input logic [31:0] ver);
    int i;
    int r;
    rec.delete();
    put_le(SIGNATURE, 8);
    put_le({32'd0, ver}, 4);
    for (r = 0; r < 4; r++) begin
      put_le(64'(run_len[r]), 8);
      for (i = 0; i < run_len[r]; i++) put_le(rand_word(), 8);
    end
    put_le(rand_word(), 8);
    put_le(rand_word(), 8);
    ext_pos = rec.size();
    put_le(64'(ext_n), 8);
    for (r = 0; r < ext_n; r++) begin
      put_le(64'(tag_len[r]), 8);
      for (i = 0; i < tag_len[r]; i++) rec.insert(rec.size(), 8'($urandom));
      put_le(64'(pay_len[r]), 8);
      for (i = 0; i < pay_len[r]; i++) rec.insert(rec.size(), 8'($urandom));
    end
  endtask

  // record bytes first, random filler past its end
  task automatic send_payload(input int plen);
    int i;
    for (i = 0; i < plen; i++) send_byte(i < rec.size() ? rec[i] : 8'($urandom));
    payloads_sent++;
  endtask

  // ---------------------------------------------------------------- tests

  // default length of one byte ends the payload inside the magic
  task automatic test_reset_defaults();
    send_byte(8'h48);
  endtask

  // length zero behaves as one
  task automatic test_zero_length();
    drain_results();
    write_reg(REG_PAYLOAD_LENGTH, 32'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // payload ends inside a wrong magic: truncated wins
  task automatic test_short_magic();
    drain_results();
    write_reg(REG_PAYLOAD_LENGTH, 32'd3);
    send_byte(8'h48);
    send_byte(8'hFF);
    send_byte(8'h45);
  endtask

  // wrong final magic byte, then one discarded byte
  task automatic test_bad_magic();
    int i;
    drain_results();
    write_reg(REG_PAYLOAD_LENGTH, 32'd9);
    for (i = 0; i < 7; i++) send_byte(SIGNATURE[8*i +: 8]);
    send_byte(8'h01);
    send_byte(8'h80);
  endtask

  // version off by one; writes past the register map must change nothing
  task automatic test_bad_version();
    int i;
    drain_results();
    write_reg(REG_UNUSED_A, 32'd0);
    write_reg(REG_UNUSED_B, 32'hFFFF_FFFF);
    write_reg(REG_PAYLOAD_LENGTH, 32'd12);
    write_reg(REG_EXPECTED_VERSION, 32'hFFFF_FFFF);
    for (i = 0; i < 8; i++) send_byte(SIGNATURE[8*i +: 8]);
    send_byte(8'hFE);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
  endtask

  // empty runs and no extensions, then empty tag and payload
  task automatic test_record_extremes();
    int i;
    drain_results();
    write_reg(REG_EXPECTED_VERSION, 32'd0);
    for (i = 0; i < 4; i++) run_len[i] = 0;
    ext_n = 0;
    build_record(32'd0);
    write_reg(REG_PAYLOAD_LENGTH, rec.size());
    send_payload(rec.size());

    drain_results();
    write_reg(REG_EXPECTED_VERSION, 32'hFFFF_FFFF);
    for (i = 0; i < 4; i++) run_len[i] = 1;
    ext_n      = 1;
    tag_len[0] = 0;
    pay_len[0] = 0;
    build_record(32'hFFFF_FFFF);
    write_reg(REG_PAYLOAD_LENGTH, rec.size());
    send_payload(rec.size());
  endtask

  // longest length gives trailing bytes, then a lowered length ends the payload
  task automatic test_length_lowered();
    drain_results();
    write_reg(REG_PAYLOAD_LENGTH, 32'hFFFF_FFFF);
    pick_shape(2, 2);
    build_record(mdl_version);
    send_payload(rec.size());
    drain_results();
    write_reg(REG_PAYLOAD_LENGTH, 32'd5);
    send_byte(8'($urandom));
  endtask

  // groups of records of one shape, some damaged, with noise payloads between,
  // until the run has sent its byte count
  task automatic test_random_records();
    int          plen;
    int          nrec;
    int          n;
    int          mode;
    logic [31:0] ver;
    logic [63:0] v;
    while (bytes_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) begin
        // noise payloads
        drain_results();
        plen = $urandom_range(1, 24);
        write_reg(REG_PAYLOAD_LENGTH, plen);
        rec.delete();
        repeat ($urandom_range(1, 3)) send_payload(plen);
      end else begin
        pick_shape(3, 2);
        case ($urandom_range(0, 5))
          0:       ver = 32'd0;
          1:       ver = 32'hFFFF_FFFF;
          default: ver = $urandom;
        endcase
        build_record(ver);
        mode = $urandom_range(0, 9);
        if (mode < 6) plen = rec.size();
        else if (mode < 8) plen = rec.size() + $urandom_range(1, 12);
        else plen = $urandom_range(1, rec.size() - 1);
        drain_results();
        write_reg(REG_EXPECTED_VERSION, ver);
        write_reg(REG_PAYLOAD_LENGTH, plen);
        nrec = $urandom_range(1, 3);
        for (n = 0; n < nrec && bytes_sent < ITEM_TARGET; n++) begin
          build_record(ver);
          case ($urandom_range(0, 9))
            0: rec[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
            1: rec[8 + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            2: begin
              // run 0 count at or past its limit
              if (plen > 20 && $urandom_range(0, 1) == 1)
                v = 64'((plen - 20) / 8 + $urandom_range(0, 1));
              else
                v = {$urandom, $urandom};
              poke_le(12, v);
            end
            3: begin
              // extension count at or past its limit
              if (plen > ext_pos + 8 && $urandom_range(0, 1) == 1)
                v = 64'((plen - ext_pos - 8) / 16 + $urandom_range(0, 1));
              else
                v = {$urandom, $urandom};
              poke_le(ext_pos, v);
            end
            default: ;
          endcase
          send_payload(plen);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    mdl_payload_len = 32'd1;
    mdl_version     = 32'd2;
    restart_parse();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_zero_length();
    test_short_magic();
    test_bad_magic();
    test_bad_version();
    test_record_extremes();
    test_length_lowered();
    test_random_records();
    drain_results();

    if (pending_results.size() != 0)
      $display("%0t %0d expected results never arrived", $time, pending_results.size());
    $display("sent %0d bytes in %0d payloads, checked %0d results, %0d failures",
             bytes_sent, payloads_sent, results_seen, errors);
    $display("%s %s", "ran short, zero-length and lowered lengths, bad magic and version,",
             "oversized counts, trailing and truncated records");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[length_prefixed_record_validator] OK");
    end else begin
      $display("[length_prefixed_record_validator] ERROR");
    end
    $finish;
  end

endmodule
